// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the packetizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define FFP_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("%m: check failed");

// Checks that a condition never becomes true outside reset.
`define FFP_NEVER(label, clk, rst_n, cond) \
	`FFP_ASSERT(label, clk, rst_n, !(cond))

`endif

// ===== hw/rtl/ffp_pkg.sv =====
package ffp_pkg;

	localparam int FRAME_SIZE_BITS = 24;
	localparam int CMP_W = (FRAME_SIZE_BITS > 16) ? FRAME_SIZE_BITS : 16;
	localparam int DIV_W = CMP_W + 1;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	localparam int HDR_BYTES = 12;
	localparam logic [3:0] HDR_SEL_LAST = 4'(HDR_BYTES - 1);

	localparam int ADDR_W = 3;
	localparam logic REG_IDX_PAYLOAD_MAX = 1'b0;
	localparam logic [15:0] PAYLOAD_MAX_RESET = 16'd1400;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        start_of_frame;
		logic [31:0] frame_stamp;
		logic [23:0] frame_len;
	} src_word_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        end_of_packet;
		logic [16:0] packet_length;
	} pkt_word_t;

	typedef struct packed {
		logic       capture;
		logic       div_start;
		logic       frame_init;
		logic       load_chunk;
		logic       emit_hdr;
		logic       hdr_last;
		logic       emit_pay;
		logic [3:0] hdr_sel;
	} ffp_cmd_t;

	typedef struct packed {
		logic active;
		logic chunk_start;
		logic out_free;
		logic div_done;
	} ffp_stat_t;

endpackage

// ===== hw/rtl/ffp_div.sv =====
module ffp_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ffp_pkg::DIV_W-1:0] dividend,
	input  logic [15:0]               divisor,
	output logic                      done,
	output logic [ffp_pkg::DIV_W-1:0] quotient
);
	import ffp_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [15:0]          rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [15:0]          divisor_q;
	logic [16:0]          rem_sh;
	logic [16:0]          rem_sub;
	logic                 ge;

	assign rem_sh  = {rem_q, quo_q[DIV_W-1]};
	assign ge      = rem_sh >= {1'b0, divisor_q};
	assign rem_sub = rem_sh - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? rem_sub[15:0] : rem_sh[15:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hw/rtl/ffp_ctrl.sv =====
`include "assert_macros.svh"

module ffp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	input  logic               src_sof,
	output logic               src_stall,
	input  ffp_pkg::ffp_stat_t stat,
	output ffp_pkg::ffp_cmd_t  cmd
);
	import ffp_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_EVAL = 3'd2;
	localparam logic [2:0] ST_HDR  = 3'd3;
	localparam logic [2:0] ST_PAY  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [3:0] hdr_cnt_q;
	logic [3:0] hdr_cnt_d;
	logic       accept;

	assign src_stall = state_q != ST_IDLE;
	assign accept    = src_valid && (state_q == ST_IDLE);

	always_comb begin
		state_d     = state_q;
		hdr_cnt_d   = hdr_cnt_q;
		cmd         = '0;
		cmd.hdr_sel = hdr_cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					if (src_sof) begin
						cmd.div_start = 1'b1;
						state_d       = ST_DIV;
					end else if (stat.active && stat.chunk_start) begin
						cmd.load_chunk = 1'b1;
						hdr_cnt_d      = '0;
						state_d        = ST_HDR;
					end else if (stat.active) begin
						state_d = ST_PAY;
					end
				end
			end
			ST_DIV: begin
				if (stat.div_done) begin
					cmd.frame_init = 1'b1;
					state_d        = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (stat.active && stat.chunk_start) begin
					cmd.load_chunk = 1'b1;
					hdr_cnt_d      = '0;
					state_d        = ST_HDR;
				end else if (stat.active) begin
					state_d = ST_PAY;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_HDR: begin
				if (stat.out_free) begin
					cmd.emit_hdr = 1'b1;
					hdr_cnt_d    = hdr_cnt_q + 1'b1;
					if (hdr_cnt_q == HDR_SEL_LAST) begin
						cmd.hdr_last = 1'b1;
						state_d      = ST_PAY;
					end
				end
			end
			ST_PAY: begin
				if (stat.out_free) begin
					cmd.emit_pay = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			hdr_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			hdr_cnt_q <= hdr_cnt_d;
		end
	end

	`FFP_ASSERT(a_emit_needs_room, clk, arst_n, (cmd.emit_hdr || cmd.emit_pay) |-> stat.out_free)
	`FFP_ASSERT(a_done_in_div, clk, arst_n, stat.div_done |-> (state_q == ST_DIV))
	`FFP_NEVER(a_hdr_count_range, clk, arst_n, (state_q == ST_HDR) && (hdr_cnt_q > HDR_SEL_LAST))

endmodule

// ===== hw/rtl/ffp_dp.sv =====
`include "assert_macros.svh"

module ffp_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  ffp_pkg::src_word_t src_word,
	input  logic [15:0]        payload_max,
	input  ffp_pkg::ffp_cmd_t  cmd,
	output ffp_pkg::ffp_stat_t stat,
	output logic               pkt_valid,
	input  logic               pkt_stall,
	output ffp_pkg::pkt_word_t pkt_word
);
	import ffp_pkg::*;

	logic [7:0]                 data_q;
	logic [31:0]                pend_ts_q;
	logic [FRAME_SIZE_BITS-1:0] pend_size_q;
	logic [31:0]                seq_q;
	logic [31:0]                ts_q;
	logic [FRAME_SIZE_BITS-1:0] remaining_q;
	logic [15:0]                frag_idx_q;
	logic [15:0]                frag_cnt_q;
	logic [15:0]                chunk_pos_q;
	logic                       dropped_q;
	logic [15:0]                frame_pmax_q;
	logic [15:0]                cur_chunk_q;
	logic                       pkt_valid_q;
	pkt_word_t                  pkt_word_q;

	logic [FRAME_SIZE_BITS-1:0] size_in;
	logic [DIV_W-1:0]           dividend;
	logic [DIV_W-1:0]           quotient;
	logic                       div_done;
	logic                       drop_frame;
	logic [15:0]                chunk_len;
	logic                       last_byte;
	logic [7:0]                 hdr_byte;
	logic [16:0]                pkt_len;

	assign size_in  = FRAME_SIZE_BITS'(src_word.frame_len);
	assign dividend = DIV_W'(size_in) + DIV_W'(payload_max) - DIV_W'(1);

	ffp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (payload_max),
		.done     (div_done),
		.quotient (quotient)
	);

	assign drop_frame = (payload_max == '0) || (pend_size_q == '0) || ((quotient >> 16) != '0);
	assign chunk_len  = (CMP_W'(remaining_q) < CMP_W'(frame_pmax_q)) ? 16'(remaining_q)
	                                                                 : frame_pmax_q;
	assign last_byte  = ({1'b0, chunk_pos_q} + 17'd1) >= {1'b0, cur_chunk_q};
	assign pkt_len    = 17'(cur_chunk_q) + 17'(HDR_BYTES);

	always_comb begin
		case (cmd.hdr_sel)
			4'd0:    hdr_byte = seq_q[31:24];
			4'd1:    hdr_byte = seq_q[23:16];
			4'd2:    hdr_byte = seq_q[15:8];
			4'd3:    hdr_byte = seq_q[7:0];
			4'd4:    hdr_byte = ts_q[31:24];
			4'd5:    hdr_byte = ts_q[23:16];
			4'd6:    hdr_byte = ts_q[15:8];
			4'd7:    hdr_byte = ts_q[7:0];
			4'd8:    hdr_byte = frag_idx_q[15:8];
			4'd9:    hdr_byte = frag_idx_q[7:0];
			4'd10:   hdr_byte = frag_cnt_q[15:8];
			4'd11:   hdr_byte = frag_cnt_q[7:0];
			default: hdr_byte = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			data_q      <= src_word.data_byte;
			pend_ts_q   <= src_word.frame_stamp;
			pend_size_q <= size_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q        <= '0;
			ts_q         <= '0;
			remaining_q  <= '0;
			frag_idx_q   <= '0;
			frag_cnt_q   <= '0;
			chunk_pos_q  <= '0;
			dropped_q    <= 1'b0;
			frame_pmax_q <= '0;
			cur_chunk_q  <= '0;
		end else begin
			if (cmd.frame_init) begin
				ts_q         <= pend_ts_q;
				chunk_pos_q  <= '0;
				frag_idx_q   <= '0;
				cur_chunk_q  <= '0;
				frame_pmax_q <= payload_max;
				dropped_q    <= drop_frame;
				remaining_q  <= drop_frame ? '0 : pend_size_q;
				frag_cnt_q   <= drop_frame ? '0 : 16'(quotient);
			end
			if (cmd.load_chunk) begin
				cur_chunk_q <= chunk_len;
			end
			if (cmd.hdr_last) begin
				seq_q <= seq_q + 32'd1;
			end
			if (cmd.emit_pay) begin
				remaining_q <= remaining_q - 1'b1;
				if (last_byte) begin
					chunk_pos_q <= '0;
					frag_idx_q  <= frag_idx_q + 16'd1;
				end else begin
					chunk_pos_q <= chunk_pos_q + 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_valid_q <= 1'b0;
		end else if (cmd.emit_hdr || cmd.emit_pay) begin
			pkt_valid_q <= 1'b1;
		end else if (!pkt_stall) begin
			pkt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_hdr) begin
			pkt_word_q.out_byte      <= hdr_byte;
			pkt_word_q.end_of_packet <= 1'b0;
			pkt_word_q.packet_length <= pkt_len;
		end else if (cmd.emit_pay) begin
			pkt_word_q.out_byte      <= data_q;
			pkt_word_q.end_of_packet <= last_byte;
			pkt_word_q.packet_length <= pkt_len;
		end
	end

	assign stat.active      = !dropped_q && (remaining_q != '0);
	assign stat.chunk_start = chunk_pos_q == '0;
	assign stat.out_free    = !pkt_valid_q || !pkt_stall;
	assign stat.div_done    = div_done;

	assign pkt_valid = pkt_valid_q;
	assign pkt_word  = pkt_word_q;

	`FFP_ASSERT(a_pay_has_chunk, clk, arst_n, cmd.emit_pay |-> (cur_chunk_q != '0))
	`FFP_ASSERT(a_pay_inside_chunk, clk, arst_n, cmd.emit_pay |-> (chunk_pos_q < cur_chunk_q))
	`FFP_ASSERT(a_word_held, clk, arst_n, (pkt_valid_q && pkt_stall) |=> (pkt_valid_q && $stable(pkt_word_q)))

endmodule

// ===== hw/rtl/frame_fragment_packetizer.sv =====
// Splits a byte-wide frame into fragment packets of at most payload_max payload bytes, each
// preceded by a 12-byte big-endian header (sequence number, timestamp, fragment index, fragment
// total). A word flagged start_of_frame starts a new frame, and its first output word waits for the
// bit-serial divider that works out the fragment total one quotient bit per cycle; the first byte
// of each fragment then takes 13 output words, and every other byte is first accepted and then
// loaded into the output register. Frames with a zero size, a zero payload_max or more than 65535
// fragments give no output. payload_max is sampled at frame start.
module frame_fragment_packetizer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            src_valid,
	output logic                            src_stall,
	input  ffp_pkg::src_word_t              src_word,
	output logic                            pkt_valid,
	input  logic                            pkt_stall,
	output ffp_pkg::pkt_word_t              pkt_word,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ffp_pkg::ADDR_W-1:0]      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import ffp_pkg::*;

	logic [15:0] payload_max_q;
	ffp_cmd_t    cmd;
	ffp_stat_t   stat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_IDX_PAYLOAD_MAX) ? {16'd0, payload_max_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_max_q <= PAYLOAD_MAX_RESET;
		end else if (psel && penable && pwrite && pready
		             && (paddr[2] == REG_IDX_PAYLOAD_MAX)) begin
			payload_max_q <= pwdata[15:0];
		end
	end

	ffp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_sof   (src_word.start_of_frame),
		.src_stall (src_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	ffp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_word    (src_word),
		.payload_max (payload_max_q),
		.cmd         (cmd),
		.stat        (stat),
		.pkt_valid   (pkt_valid),
		.pkt_stall   (pkt_stall),
		.pkt_word    (pkt_word)
	);

endmodule

// ===== sim/frame_fragment_packetizer_tb.sv =====
module frame_fragment_packetizer_tb;
	import ffp_pkg::*;

	localparam int KEEP_CFG = -1;
	localparam int ANY_COUNT = -1;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 135;
	localparam int CALM_AFTER = 110;
	localparam logic [ADDR_W-1:0] PAYLOAD_MAX_ADDR = ADDR_W'(4 * int'(REG_IDX_PAYLOAD_MAX));

	typedef struct {
		int          cfg;
		logic [7:0]  data;
		bit          sof;
		logic [31:0] ts;
		logic [23:0] size;
		int          results;
	} directed_step_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              src_valid = 1'b0;
	logic              src_stall;
	src_word_t         src_word = '0;
	logic              pkt_valid;
	logic              pkt_stall = 1'b0;
	pkt_word_t         pkt_word;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	pkt_word_t queued_packet_words[$];
	int mismatches = 0;
	int sent_items = 0;
	int cycle_count = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	// Packetizer state as the block should hold it.
	logic [15:0] pmax_reg = PAYLOAD_MAX_RESET;
	logic [31:0] seq_num = '0;
	logic [31:0] ts_hold = '0;
	logic [23:0] bytes_left = '0;
	logic [15:0] frag_idx = '0;
	logic [15:0] frag_count = '0;
	logic [15:0] chunk_pos = '0;
	logic [15:0] frame_pmax = '0;
	logic [15:0] chunk_len = '0;
	bit          dropped = 1'b0;

	directed_step_t steps [0:22];

	frame_fragment_packetizer DUT (.*);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic packetize_byte(input src_word_t w, output int produced);
		logic [31:0] total;
		logic [95:0] header;
		pkt_word_t pw;
		bit last;
		produced = 0;
		if (w.start_of_frame) begin
			ts_hold = w.frame_stamp;
			chunk_pos = '0;
			frag_idx = '0;
			chunk_len = '0;
			frame_pmax = pmax_reg;
			total = '0;
			if (pmax_reg != 0 && w.frame_len != 0)
				total = (32'(w.frame_len) + 32'(pmax_reg) - 1) / 32'(pmax_reg);
			if (total == 0 || total > 32'hFFFF) begin
				dropped = 1'b1;
				bytes_left = '0;
				frag_count = '0;
			end else begin
				dropped = 1'b0;
				bytes_left = w.frame_len;
				frag_count = total[15:0];
			end
		end
		if (dropped || bytes_left == 0)
			return;
		if (chunk_pos == 0) begin
			chunk_len = (bytes_left < 24'(frame_pmax)) ? bytes_left[15:0] : frame_pmax;
			header = {seq_num, ts_hold, frag_idx, frag_count};
			for (int k = 0; k < HDR_BYTES; k++) begin
				pw.out_byte = header[95 - 8 * k -: 8];
				pw.end_of_packet = 1'b0;
				pw.packet_length = 17'(HDR_BYTES) + 17'(chunk_len);
				queued_packet_words.push_back(pw);
				produced++;
			end
			seq_num++;
		end
		last = (32'(chunk_pos) + 1) >= 32'(chunk_len);
		pw.out_byte = w.data_byte;
		pw.end_of_packet = last;
		pw.packet_length = 17'(HDR_BYTES) + 17'(chunk_len);
		queued_packet_words.push_back(pw);
		produced++;
		bytes_left--;
		if (last) begin
			chunk_pos = '0;
			frag_idx++;
		end else begin
			chunk_pos++;
		end
	endtask

	always @(posedge clk) begin
		pkt_word_t want;
		if (arst_n && pkt_valid && !pkt_stall) begin
			if (queued_packet_words.size() == 0) begin
				mismatches++;
				$display("%0t: word expected none, actual %h", $time, pkt_word);
			end else begin
				want = queued_packet_words.pop_front();
				if (pkt_word.out_byte !== want.out_byte) begin
					mismatches++;
					$display("%0t: out_byte expected %h, actual %h", $time,
						want.out_byte, pkt_word.out_byte);
				end
				if (pkt_word.end_of_packet !== want.end_of_packet) begin
					mismatches++;
					$display("%0t: end_of_packet expected %b, actual %b", $time,
						want.end_of_packet, pkt_word.end_of_packet);
				end
				if (pkt_word.packet_length !== want.packet_length) begin
					mismatches++;
					$display("%0t: packet_length expected %0d, actual %0d", $time,
						want.packet_length, pkt_word.packet_length);
				end
			end
		end
		if (stall_left > 0)
			stall_left--;
		else if (!calm && $urandom_range(0, 15) == 0)
			stall_left = $urandom_range(1, 14);
		pkt_stall <= (stall_left > 0);
	end

	task automatic send_frame_byte(input src_word_t w, output int produced);
		if (!calm && $urandom_range(0, 7) == 0) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_word <= w;
		do @(posedge clk); while (src_stall);
		packetize_byte(w, produced);
		sent_items++;
	endtask

	task automatic wait_drained();
		src_valid <= 1'b0;
		while (queued_packet_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_payload_max(input logic [15:0] value);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PAYLOAD_MAX_ADDR;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		pmax_reg = value;
	endtask

	task automatic send_random_frame();
		src_word_t w;
		int n_bytes;
		int produced;
		logic [23:0] size;
		logic [31:0] ts;
		if ($urandom_range(0, 5) == 0) begin
			case ($urandom_range(0, 5))
				0: set_payload_max(16'd0);
				1: set_payload_max(16'hFFFF);
				2: set_payload_max(16'($urandom_range(13, 65535)));
				default: set_payload_max(16'($urandom_range(1, 12)));
			endcase
		end
		ts = $urandom;
		case ($urandom_range(0, 19))
			0: begin
				w = src_word_t'({$urandom, $urandom});
				w.start_of_frame = 1'b0;
				send_frame_byte(w, produced);
				return;
			end
			1: begin
				size = '0;
				n_bytes = $urandom_range(1, 3);
			end
			2: begin
				size = 24'($urandom);
				n_bytes = $urandom_range(1, 6);
			end
			3: begin
				size = 24'($urandom_range(2, 40));
				n_bytes = $urandom_range(1, int'(size) - 1);
			end
			default: begin
				size = 24'($urandom_range(1, 40));
				n_bytes = int'(size) + (($urandom_range(0, 4) == 0) ? 1 : 0);
			end
		endcase
		for (int i = 0; i < n_bytes; i++) begin
			w.data_byte = 8'($urandom);
			w.start_of_frame = (i == 0);
			w.frame_stamp = (i == 0) ? ts : $urandom;
			w.frame_len = (i == 0) ? size : 24'($urandom);
			send_frame_byte(w, produced);
		end
	endtask

	initial begin
		src_word_t w;
		int produced;
		steps = '{
			'{KEEP_CFG, 8'hA5, 1'b0, 32'h0000_0000, 24'd0,      0},
			'{KEEP_CFG, 8'hFF, 1'b1, 32'hFFFF_FFFF, 24'd1,      13},
			'{KEEP_CFG, 8'h00, 1'b0, 32'h0000_0000, 24'hFFFFFF, 0},
			'{3,        8'h00, 1'b1, 32'h0000_0000, 24'd5,      13},
			'{KEEP_CFG, 8'h11, 1'b0, 32'h1234_5678, 24'd0,      1},
			'{KEEP_CFG, 8'h22, 1'b0, 32'h0000_0000, 24'd0,      1},
			'{KEEP_CFG, 8'h33, 1'b0, 32'h0000_0000, 24'd0,      13},
			'{KEEP_CFG, 8'h44, 1'b0, 32'h0000_0000, 24'd0,      1},
			'{0,        8'h55, 1'b1, 32'hDEAD_BEEF, 24'd10,     0},
			'{KEEP_CFG, 8'h66, 1'b0, 32'h0000_0000, 24'd0,      0},
			'{1,        8'h77, 1'b1, 32'h0F0F_0F0F, 24'hFFFFFF, 0},
			'{256,      8'h88, 1'b1, 32'hF0F0_F0F0, 24'hFFFFFF, 0},
			'{257,      8'h99, 1'b1, 32'h8000_0001, 24'hFFFFFF, 13},
			'{KEEP_CFG, 8'hAA, 1'b0, 32'h0000_0000, 24'd0,      1},
			'{KEEP_CFG, 8'hBB, 1'b1, 32'h5555_AAAA, 24'd0,      0},
			'{65535,    8'hCC, 1'b1, 32'hAAAA_5555, 24'd3,      13},
			'{1,        8'hDD, 1'b0, 32'h0000_0000, 24'd0,      1},
			'{KEEP_CFG, 8'hEE, 1'b0, 32'h0000_0000, 24'd0,      1},
			'{4,        8'h01, 1'b1, 32'h0000_0001, 24'd8,      13},
			'{KEEP_CFG, 8'h02, 1'b0, 32'h0000_0000, 24'd0,      1},
			'{KEEP_CFG, 8'h03, 1'b1, 32'h7FFF_FFFF, 24'd2,      13},
			'{KEEP_CFG, 8'h04, 1'b0, 32'h0000_0000, 24'd0,      1},
			'{KEEP_CFG, 8'h05, 1'b0, 32'h0000_0000, 24'd0,      0}
		};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (steps[i]) begin
			if (steps[i].cfg != KEEP_CFG)
				set_payload_max(16'(steps[i].cfg));
			w.data_byte = steps[i].data;
			w.start_of_frame = steps[i].sof;
			w.frame_stamp = steps[i].ts;
			w.frame_len = steps[i].size;
			send_frame_byte(w, produced);
			if (steps[i].results != ANY_COUNT && produced != steps[i].results) begin
				mismatches++;
				$display("%0t: directed row %0d words expected %0d, actual %0d", $time, i,
					steps[i].results, produced);
			end
		end
		sent_items = 0;
		while (sent_items < RANDOM_ITEMS) begin
			calm = (sent_items >= CALM_AFTER);
			send_random_frame();
		end
		wait_drained();
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
